// ===== sv/skcm_pkg.sv =====
// Shared constants, types and key helper for the sorted key-to-command map.
// No dependencies; every other file of the block except skcm_ram refers to this package.
`default_nettype none

package skcm_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int HALF_W = 32;
    localparam int KEY_W  = 2 * HALF_W;
    localparam int CMD_W  = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 3;

    // Item kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_ADD    = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_LOOKUP   = 3'd0;
    localparam logic [STAT_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_RESERVED = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    // Flipping the sign bit of the upper half makes unsigned order match signed order
    localparam logic [HALF_W-1:0] SIGN_BIAS = {1'b1, {(HALF_W-1){1'b0}}};

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CMD_W-1:0] cmd;
    } t_entry;

    typedef struct packed {
        logic              kind;
        logic [HALF_W-1:0] key_code;
        logic [HALF_W-1:0] modifier_flags;
        logic [CMD_W-1:0]  new_command;
    } t_item;

    typedef struct packed {
        logic              found;
        logic [CMD_W-1:0]  mapped_command;
        logic [POS_W-1:0]  position;
        logic [STAT_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic lt;
        logic gt;
    } t_cmp_res;

    // Compared key: biased flags on top, raw key code below
    function automatic logic [KEY_W-1:0] make_key(input logic [HALF_W-1:0] code,
                                                  input logic [HALF_W-1:0] flags);
        make_key = {flags ^ SIGN_BIAS, code};
    endfunction

endpackage

`default_nettype wire

// ===== sv/skcm_channels.sv =====
// Valid/ready channel interfaces for lookup/add items and their results.
// Depends on skcm_pkg for field widths.
`default_nettype none

interface skcm_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [skcm_pkg::HALF_W-1:0]  key_code;
    logic signed [skcm_pkg::HALF_W-1:0]  modifier_flags;
    logic signed [skcm_pkg::CMD_W-1:0]   new_command;

    modport source (output valid, kind, key_code, modifier_flags, new_command,
                    input ready);
    modport sink   (input valid, kind, key_code, modifier_flags, new_command,
                    output ready);
endinterface

interface skcm_out_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic signed [skcm_pkg::CMD_W-1:0]   mapped_command;
    logic        [skcm_pkg::POS_W-1:0]   position;
    logic        [skcm_pkg::STAT_W-1:0]  status;

    modport source (output valid, found, mapped_command, position, status,
                    input ready);
    modport sink   (input valid, found, mapped_command, position, status,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/skcm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependency.
`default_nettype none

module skcm_ram #(
    parameter  int DATA_W = 96,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/skcm_cmp.sv =====
// Shared 64-bit key magnitude comparator used by every search probe.
// Depends on skcm_pkg for the key width and result struct.
`default_nettype none

module skcm_cmp (
    input  wire logic [skcm_pkg::KEY_W-1:0] i_stored,
    input  wire logic [skcm_pkg::KEY_W-1:0] i_probe,
    output skcm_pkg::t_cmp_res              o_res
);

    // Stored key relative to the probe key, unsigned
    always_comb begin
        o_res.lt = (i_stored < i_probe);
        o_res.gt = (i_stored > i_probe);
    end

endmodule

`default_nettype wire

// ===== sv/skcm_seq.sv =====
// Sequencer: binary search over the entry RAM, replace, and one-entry-per-cycle
// shift for insertion. Depends on skcm_pkg, skcm_ram and skcm_cmp.
`default_nettype none

module skcm_seq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire skcm_pkg::t_item              i_item,
    input  wire logic [skcm_pkg::CMD_W-1:0]   i_reserved,
    output logic                              o_res_valid,
    input  wire logic                         i_res_take,
    output skcm_pkg::t_result                 o_res
);

    localparam int IDX_W = skcm_pkg::IDX_W;
    localparam int CNT_W = skcm_pkg::CNT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROBE  = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [CNT_W-1:0]                r_lo, n_lo;
    logic [CNT_W-1:0]                r_hi, n_hi;
    logic [IDX_W-1:0]                r_mid, n_mid;
    logic [IDX_W-1:0]                r_j, n_j;
    logic [CNT_W-1:0]                r_pos, n_pos;
    logic                            r_kind, n_kind;
    logic [skcm_pkg::KEY_W-1:0]      r_key, n_key;
    logic [skcm_pkg::CMD_W-1:0]      r_cmd, n_cmd;
    logic                            r_found, n_found;
    logic [skcm_pkg::CMD_W-1:0]      r_mapped, n_mapped;
    logic [skcm_pkg::STAT_W-1:0]     r_status, n_status;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    skcm_pkg::t_entry                ram_wdata;
    logic [IDX_W-1:0]                ram_raddr;
    skcm_pkg::t_entry                ram_rdata;
    skcm_pkg::t_cmp_res              cmp;

    logic [CNT_W:0]                  mid_sum;
    logic [IDX_W-1:0]                mid;
    logic [IDX_W-1:0]                last_idx;
    logic [IDX_W-1:0]                lo_idx;

    skcm_ram #(
        .DATA_W ($bits(skcm_pkg::t_entry)),
        .DEPTH  (skcm_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    skcm_cmp u_cmp (
        .i_stored (ram_rdata.key),
        .i_probe  (r_key),
        .o_res    (cmp)
    );

    // Search midpoint and index helpers
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[IDX_W:1];
    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign lo_idx   = r_lo[IDX_W-1:0];

    // Next-state and memory control
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_j       = r_j;
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_key     = r_key;
        n_cmd     = r_cmd;
        n_found   = r_found;
        n_mapped  = r_mapped;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_mid;
        ram_wdata = skcm_pkg::t_entry'{key: r_key, cmd: r_cmd};
        ram_raddr = mid;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind   = i_item.kind;
                    n_key    = skcm_pkg::make_key(i_item.key_code, i_item.modifier_flags);
                    n_cmd    = i_item.new_command;
                    n_found  = 1'b0;
                    n_mapped = '0;
                    n_lo     = '0;
                    n_hi     = r_count;
                    if (i_item.kind == skcm_pkg::KIND_ADD && i_item.new_command == i_reserved) begin
                        n_pos    = '0;
                        n_status = skcm_pkg::ST_RESERVED;
                        n_state  = S_DONE;
                    end else begin
                        n_state  = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    // issue read of the midpoint entry
                    n_mid   = mid;
                    n_state = S_CMP;
                end else begin
                    // miss: r_lo is the insertion point
                    n_pos = r_lo;
                    if (r_kind == skcm_pkg::KIND_LOOKUP) begin
                        n_status = skcm_pkg::ST_LOOKUP;
                        n_state  = S_DONE;
                    end else if (r_count >= CNT_W'(skcm_pkg::TABLE_DEPTH)) begin
                        n_status = skcm_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else if (r_count > r_lo) begin
                        ram_raddr = last_idx;
                        n_j       = last_idx;
                        n_state   = S_SHIFT;
                    end else begin
                        n_state   = S_INSERT;
                    end
                end
            end
            S_CMP: begin
                priority if (cmp.lt) begin
                    n_lo    = CNT_W'(r_mid) + CNT_W'(1);
                    n_state = S_PROBE;
                end else if (cmp.gt) begin
                    n_hi    = CNT_W'(r_mid);
                    n_state = S_PROBE;
                end else begin
                    n_found = 1'b1;
                    n_pos   = CNT_W'(r_mid);
                    if (r_kind == skcm_pkg::KIND_LOOKUP) begin
                        n_mapped = ram_rdata.cmd;
                        n_status = skcm_pkg::ST_LOOKUP;
                    end else begin
                        ram_we   = 1'b1;
                        n_status = skcm_pkg::ST_REPLACED;
                    end
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // move entry j up by one while fetching entry j-1
                ram_we    = 1'b1;
                ram_waddr = r_j + IDX_W'(1);
                ram_wdata = ram_rdata;
                if (r_j == lo_idx) begin
                    n_state = S_INSERT;
                end else begin
                    n_j       = r_j - IDX_W'(1);
                    ram_raddr = r_j - IDX_W'(1);
                end
            end
            S_INSERT: begin
                ram_we    = 1'b1;
                ram_waddr = lo_idx;
                n_count   = r_count + CNT_W'(1);
                n_status  = skcm_pkg::ST_INSERTED;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_j      <= n_j;
        r_pos    <= n_pos;
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_cmd    <= n_cmd;
        r_found  <= n_found;
        r_mapped <= n_mapped;
        r_status <= n_status;
    end

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.found          = r_found;
    assign o_res.mapped_command = r_mapped;
    assign o_res.position       = skcm_pkg::POS_W'(r_pos);
    assign o_res.status         = r_status;

`ifndef SYNTHESIS
    // Entry count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(skcm_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Search window stays ordered
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo <= r_hi) && (r_hi <= r_count))
        else $error("search window out of order");

    // An insertion grows the table by exactly one entry
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not bump entry count");

    // Memory is written only while an add item is at work
    a_write_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_kind == skcm_pkg::KIND_ADD) &&
                   (r_state == S_CMP || r_state == S_SHIFT || r_state == S_INSERT))
        else $error("unexpected entry write");

    // Table-full is only reported with a full table
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_status == skcm_pkg::ST_FULL) |->
            (r_count == CNT_W'(skcm_pkg::TABLE_DEPTH)))
        else $error("table full reported with room left");
`endif

endmodule

`default_nettype wire

// ===== sv/sorted_key_command_map_core.sv =====
// Sorted key-to-command map: one item in, one result out, table held in a single RAM
// searched and shifted by a small sequencer. Each search probe reads the midpoint entry
// from the RAM in S_PROBE and compares its key in S_CMP. An add that
// inserts moves each higher entry up at one entry per cycle through the RAM's single
// read and write port after the search, then writes the new entry in S_INSERT.
// A replace or reject finishes after the search or at once.
// The block takes one item at a time; a finished result waits in the output register
// while the next item is already accepted. The table needs no clearing after reset.
`default_nettype none

module sorted_key_command_map_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic signed [skcm_pkg::CMD_W-1:0]   i_cfg_wdata,
    skcm_in_if.sink                                  i_item,
    skcm_out_if.source                               o_result
);

    logic [skcm_pkg::CMD_W-1:0] r_reserved;
    skcm_pkg::t_item            item;
    skcm_pkg::t_result          res;
    logic                       res_valid;
    logic                       res_take;
    logic                       out_free;
    logic                       r_out_valid;
    skcm_pkg::t_result          r_out;

    // Reserved command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= '0;
        end else if (i_cfg_we) begin
            r_reserved <= i_cfg_wdata;
        end
    end

    assign item.kind           = i_item.kind;
    assign item.key_code       = i_item.key_code;
    assign item.modifier_flags = i_item.modifier_flags;
    assign item.new_command    = i_item.new_command;

    skcm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_item      (item),
        .i_reserved  (r_reserved),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // Output register: loads when empty or when its transfer completes
    assign out_free = !r_out_valid || o_result.ready;
    assign res_take = res_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.found          = r_out.found;
    assign o_result.mapped_command = r_out.mapped_command;
    assign o_result.position       = r_out.position;
    assign o_result.status         = r_out.status;

endmodule

`default_nettype wire

// ===== test/tb_sorted_key_command_map_core.sv =====
// Self-checking testbench for sorted_key_command_map_core: lookups, adds, replaces, rejects
// and a full table, all checked against an in-bench copy of the key table.
// Depends on skcm_pkg and the skcm_in_if / skcm_out_if channel interfaces.

module tb_sorted_key_command_map_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int POOL_SIZE    = 96;
    localparam int CHUNK_ITEMS  = 207;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_PRINTS   = 20;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_STALLS
    } t_rdy_mode;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              cfg_we;
    logic signed [skcm_pkg::CMD_W-1:0] cfg_wdata;

    skcm_in_if  item_if ();
    skcm_out_if res_if ();

    sorted_key_command_map_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_result    (res_if)
    );

    // Bench copy of the map: sorted keys with their commands
    bit [skcm_pkg::KEY_W-1:0]   tbl_key [skcm_pkg::TABLE_DEPTH];
    bit [skcm_pkg::CMD_W-1:0]   tbl_cmd [skcm_pkg::TABLE_DEPTH];
    int unsigned                tbl_count;
    bit [skcm_pkg::CMD_W-1:0]   reserved_cmd;

    skcm_pkg::t_item            item_q [$];
    skcm_pkg::t_result          result_q [$];
    int                         items_open;
    int                         mismatches;
    int                         results_checked;
    int                         status_seen [5];
    int                         lookup_hits;
    int                         cfg_writes;

    bit [skcm_pkg::HALF_W-1:0]  pool_code  [POOL_SIZE];
    bit [skcm_pkg::HALF_W-1:0]  pool_flags [POOL_SIZE];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Binary search over the bench table; pos gets match index or insertion point
    function automatic bit key_search(input bit [skcm_pkg::KEY_W-1:0] k,
                                      output int unsigned pos);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tbl_key[mid] < k)
                lo = mid + 1;
            else if (tbl_key[mid] > k)
                hi = mid;
            else begin
                pos = mid;
                return 1'b1;
            end
        end
        pos = lo;
        return 1'b0;
    endfunction

    // Applies one item to the bench table and returns the result it should give
    function automatic skcm_pkg::t_result map_apply(input skcm_pkg::t_item it);
        skcm_pkg::t_result          r;
        bit [skcm_pkg::KEY_W-1:0]   k;
        int unsigned                pos;
        bit                         hit;
        r = '0;
        pos = 0;
        // flags biased so that unsigned order of the whole key follows signed flags
        k = {it.modifier_flags ^ skcm_pkg::SIGN_BIAS, it.key_code};
        if (it.kind == skcm_pkg::KIND_LOOKUP) begin
            hit = key_search(k, pos);
            r.found = hit;
            if (hit) begin
                r.mapped_command = tbl_cmd[pos];
                lookup_hits++;
            end
            r.status = skcm_pkg::ST_LOOKUP;
        end else if (it.new_command == reserved_cmd) begin
            r.status = skcm_pkg::ST_RESERVED;
        end else begin
            hit = key_search(k, pos);
            if (hit) begin
                r.found = 1'b1;
                tbl_cmd[pos] = it.new_command;
                r.status = skcm_pkg::ST_REPLACED;
            end else if (tbl_count >= skcm_pkg::TABLE_DEPTH) begin
                r.status = skcm_pkg::ST_FULL;
            end else begin
                for (int i = tbl_count; i > pos; i--) begin
                    tbl_key[i] = tbl_key[i-1];
                    tbl_cmd[i] = tbl_cmd[i-1];
                end
                tbl_key[pos] = k;
                tbl_cmd[pos] = it.new_command;
                tbl_count++;
                r.status = skcm_pkg::ST_INSERTED;
            end
        end
        r.position = pos[skcm_pkg::POS_W-1:0];
        status_seen[r.status]++;
        return r;
    endfunction

    function automatic skcm_pkg::t_item make_item(input logic kind, input bit [31:0] code,
                                                  input bit [31:0] flags,
                                                  input bit [31:0] cmd);
        skcm_pkg::t_item it;
        it.kind           = kind;
        it.key_code       = code;
        it.modifier_flags = flags;
        it.new_command    = cmd;
        return it;
    endfunction

    function automatic bit [31:0] pick_edge_word();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Random item: mostly keys from a shared pool so adds collide and lookups hit
    function automatic skcm_pkg::t_item random_item();
        skcm_pkg::t_item it;
        int unsigned     sel;
        it.kind = ($urandom_range(0, 99) < 55) ? skcm_pkg::KIND_ADD : skcm_pkg::KIND_LOOKUP;
        if ($urandom_range(0, 4) != 0) begin
            sel = $urandom_range(0, POOL_SIZE - 1);
            it.key_code       = pool_code[sel];
            it.modifier_flags = pool_flags[sel];
        end else begin
            it.key_code       = $urandom;
            it.modifier_flags = $urandom;
        end
        case ($urandom_range(0, 9))
            0: it.new_command = reserved_cmd;
            1: it.new_command = pick_edge_word();
            default: it.new_command = $urandom;
        endcase
        return it;
    endfunction

    task automatic queue_item(input skcm_pkg::t_item it);
        item_q.push_back(it);
        items_open++;
    endtask

    task automatic wait_idle();
        while (items_open != 0)
            @(posedge i_clk);
    endtask

    task automatic set_reserved(input bit [skcm_pkg::CMD_W-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        reserved_cmd = v;
        cfg_writes++;
    endtask

    // Sender: bursts of transfers separated by random gaps
    int unsigned     burst_left;
    int unsigned     gap_left;
    skcm_pkg::t_item cur_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (item_if.valid && item_if.ready)
                result_q.push_back(map_apply(cur_item));
            if (item_if.valid && !item_if.ready) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                gap_left--;
                item_if.valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                cur_item = item_q.pop_front();
                item_if.valid          <= 1'b1;
                item_if.kind           <= cur_item.kind;
                item_if.key_code       <= cur_item.key_code;
                item_if.modifier_flags <= cur_item.modifier_flags;
                item_if.new_command    <= cur_item.new_command;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a random mode, picked anew whenever its countdown runs out
    t_rdy_mode   rdy_mode;
    int unsigned rdy_left;
    int unsigned stall_left;

    always @(posedge i_clk) begin
        skcm_pkg::t_result exp;
        logic              rdy_next;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rdy_mode   = RDY_ALWAYS;
            rdy_left   = 0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result transfer with no item outstanding");
                end else begin
                    exp = result_q.pop_front();
                    if (res_if.found !== exp.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  res_if.found, exp.found));
                    if (res_if.mapped_command !== exp.mapped_command)
                        report_mismatch($sformatf("mapped_command %h, expected %h",
                                                  res_if.mapped_command, exp.mapped_command));
                    if (res_if.position !== exp.position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  res_if.position, exp.position));
                    if (res_if.status !== exp.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  res_if.status, exp.status));
                    results_checked++;
                    items_open--;
                end
            end
            if (rdy_left == 0) begin
                rdy_mode = t_rdy_mode'($urandom_range(0, 3));
                rdy_left = $urandom_range(20, 120);
            end else begin
                rdy_left--;
            end
            case (rdy_mode)
                RDY_ALWAYS: rdy_next = 1'b1;
                RDY_COIN:   rdy_next = 1'($urandom_range(0, 1));
                RDY_MOSTLY: rdy_next = ($urandom_range(0, 3) != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rdy_next = 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(1, 20);
                        rdy_next   = 1'b0;
                    end else begin
                        rdy_next = 1'b1;
                    end
                end
            endcase
            res_if.ready <= rdy_next;
        end
    end

    // Stimulus and end of run
    initial begin
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        item_if.valid          = 1'b0;
        item_if.kind           = skcm_pkg::KIND_LOOKUP;
        item_if.key_code       = '0;
        item_if.modifier_flags = '0;
        item_if.new_command    = '0;
        res_if.ready           = 1'b0;
        tbl_count    = 0;
        reserved_cmd = '0;
        items_open   = 0;
        mismatches   = 0;
        results_checked = 0;
        lookup_hits  = 0;
        cfg_writes   = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // key pool: flags clustered on the signed extremes, codes on the unsigned ones
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_flags[i] = ($urandom_range(0, 2) == 0) ? $urandom : pick_edge_word();
            pool_code[i]  = ($urandom_range(0, 1) == 0) ? $urandom : pick_edge_word();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reserved command still at its reset value of zero
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'h1111_1111, 32'h0000_0000, 32'h0000_0000));
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'h0000_0000, 32'h8000_0000, 32'h8000_0000));
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'h1234_5678, 32'h0000_0000, 32'h7FFF_FFFF));
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001));
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'h7FFF_FFFF, 32'h0000_0001, 32'hAAAA_AAAA));
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'h8000_0001, 32'h0000_0000, 32'h5555_5555));
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000));
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000));
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000));
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000));
        // same key again: command is replaced in place
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'h1234_5678, 32'h0000_0000, 32'hDEAD_BEEF));
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000));
        // lower half compares unsigned: code with top bit clear sits below it
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000));
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h8000_0001, 32'h0000_0000, 32'h0000_0000));
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h1234_5677, 32'h0000_0000, 32'h0000_0000));
        // misses just inside both ends of the table
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000));
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
        // reserved command on an existing key is still rejected
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'h1234_5678, 32'h0000_0000, 32'h0000_0000));
        queue_item(make_item(skcm_pkg::KIND_ADD,    32'h0000_0000, 32'h8000_0000, 32'h0000_0002));
        queue_item(make_item(skcm_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000));
        wait_idle();

        // Random part under several reserved commands, extremes first
        set_reserved(32'h8000_0000);
        repeat (CHUNK_ITEMS) queue_item(random_item());
        wait_idle();
        set_reserved(32'h7FFF_FFFF);
        repeat (CHUNK_ITEMS) queue_item(random_item());
        wait_idle();
        set_reserved(32'hFFFF_FFFF);
        repeat (CHUNK_ITEMS) queue_item(random_item());
        wait_idle();
        set_reserved($urandom);
        repeat (CHUNK_ITEMS) queue_item(random_item());
        wait_idle();

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (result_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", result_q.size()));

        $display("Checked %0d results under %0d reserved-command settings, %0d entries held.",
                 results_checked, cfg_writes, tbl_count);
        $display("Lookups %0d (%0d hits), replaced %0d, inserted %0d, rejected %0d, full %0d.",
                 status_seen[skcm_pkg::ST_LOOKUP], lookup_hits,
                 status_seen[skcm_pkg::ST_REPLACED], status_seen[skcm_pkg::ST_INSERTED],
                 status_seen[skcm_pkg::ST_RESERVED], status_seen[skcm_pkg::ST_FULL]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sorted_key_command_map_core.f =====
sv/skcm_pkg.sv
sv/skcm_channels.sv
sv/skcm_ram.sv
sv/skcm_cmp.sv
sv/skcm_seq.sv
sv/sorted_key_command_map_core.sv
test/tb_sorted_key_command_map_core.sv
